/* rtl/core/smar_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smar_pkg
// Types and constants shared by the sensor moving average reporter.
// ----------------------------------------------------------------------------
package smar_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned ADDR_W     = 3;
  localparam int unsigned INTERVAL_W = 16;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd500;

  localparam logic REG_PUBLISH_INTERVAL = 1'b0;

  localparam int unsigned RAW_W       = 10;
  localparam int unsigned TEMP_W      = 13;
  localparam int unsigned BATT_W      = 17;
  localparam int unsigned TEMP_PROD_W = 22;
  localparam int unsigned TEMP_V_W    = 23;
  localparam int unsigned BATT_PROD_W = 27;
  localparam int unsigned FRAC_W      = 10;

  localparam logic [TEMP_PROD_W-1:0] TEMP_GAIN   = 22'd3250;
  localparam logic [TEMP_V_W-1:0]    TEMP_OFFSET = 23'd568320;
  localparam logic [TEMP_V_W-1:0]    TEMP_ROUND  = 23'd1023;
  localparam logic [BATT_PROD_W-1:0] BATT_GAIN   = 27'd82422;

  typedef struct packed {
    logic [RAW_W-1:0] temp_raw;
    logic [RAW_W-1:0] battery_raw;
    logic [31:0]      now_ms;
  } smar_in_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] avg_temp_tenths_c;
    logic [BATT_W-1:0]        avg_battery_mv;
  } smar_out_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic [BATT_W-1:0]        battery;
  } smar_entry_t;

  typedef struct packed {
    smar_entry_t cur;
    smar_entry_t old;
    logic [31:0] now_ms;
  } smar_sample_t;

endpackage

/* rtl/core/smar_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smar_cfg_regs
// APB register file holding the report interval.
// ----------------------------------------------------------------------------
module smar_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [smar_pkg::ADDR_W-1:0]       paddr,
  input  logic [smar_pkg::DATA_W-1:0]       pwdata,
  output logic [smar_pkg::DATA_W-1:0]       prdata,
  output logic                              pready,
  output logic [smar_pkg::INTERVAL_W-1:0]   interval
);

  logic hit;

  assign hit    = (paddr[2] == smar_pkg::REG_PUBLISH_INTERVAL);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= smar_pkg::INTERVAL_RESET;
    end else if (psel && penable && pwrite && hit) begin
      interval <= pwdata[smar_pkg::INTERVAL_W-1:0];
    end
  end

  assign prdata = hit ? {{(smar_pkg::DATA_W - smar_pkg::INTERVAL_W){1'b0}}, interval}
                      : '0;

endmodule

/* rtl/core/smar_ring_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smar_ring_mem
// Sample ring: synchronous memory with per-entry valid bits cleared at reset.
// ----------------------------------------------------------------------------
module smar_ring_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned POS_W = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  logic [POS_W-1:0]      rd_addr,
  input  logic                  wr_en,
  input  logic [POS_W-1:0]      wr_addr,
  input  smar_pkg::smar_entry_t wr_data,
  output smar_pkg::smar_entry_t rd_data
);

  smar_pkg::smar_entry_t mem [DEPTH];
  smar_pkg::smar_entry_t mem_q;
  logic [DEPTH-1:0]      valid;
  logic                  rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? mem_q : '0;

endmodule

/* rtl/core/smar_accum.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smar_accum
// Running sums and report timer; decides whether a sample triggers a report.
// ----------------------------------------------------------------------------
module smar_accum #(
  parameter int unsigned POS_W = 4
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  fire,
  input  smar_pkg::smar_sample_t                sample,
  input  logic [smar_pkg::INTERVAL_W-1:0]       interval,
  output logic                                  report,
  output logic signed [smar_pkg::TEMP_W+POS_W-1:0] temp_sum_next,
  output logic [smar_pkg::BATT_W+POS_W-1:0]     battery_sum_next
);

  localparam int unsigned TSUM_W = smar_pkg::TEMP_W + POS_W;
  localparam int unsigned BSUM_W = smar_pkg::BATT_W + POS_W;

  logic signed [TSUM_W-1:0] temp_sum;
  logic [BSUM_W-1:0]        battery_sum;
  logic [31:0]              last_report_ms;
  logic                     timer_started;
  logic [31:0]              base_ms;
  logic [31:0]              elapsed;

  assign temp_sum_next = temp_sum
                       - {{POS_W{sample.old.temp[smar_pkg::TEMP_W-1]}}, sample.old.temp}
                       + {{POS_W{sample.cur.temp[smar_pkg::TEMP_W-1]}}, sample.cur.temp};
  assign battery_sum_next = battery_sum
                          - {{POS_W{1'b0}}, sample.old.battery}
                          + {{POS_W{1'b0}}, sample.cur.battery};

  assign base_ms = timer_started ? last_report_ms : sample.now_ms;
  assign elapsed = sample.now_ms - base_ms;
  assign report  = elapsed > {{(32 - smar_pkg::INTERVAL_W){1'b0}}, interval};

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_sum       <= '0;
      battery_sum    <= '0;
      last_report_ms <= '0;
      timer_started  <= 1'b0;
    end else if (fire) begin
      temp_sum      <= temp_sum_next;
      battery_sum   <= battery_sum_next;
      timer_started <= 1'b1;
      if (report || !timer_started) begin
        last_report_ms <= sample.now_ms;
      end
    end
  end

endmodule

/* rtl/core/sensor_moving_average_reporter_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_moving_average_reporter_unit
// Moving averages of temperature and battery samples, reported on a timer.
// ----------------------------------------------------------------------------
// Samples enter on the sample channel (valid/ready); each carries a
// temperature and a battery converter code plus a millisecond timestamp.
// Converted values replace the oldest entry of a ring of AVG_DEPTH entries
// kept in one synchronous memory, and running sums follow each write.
// When more than publish_interval_ms has passed since the last report,
// the ring means leave on the report channel (valid/ready).
// Throughput: one sample per cycle while reports are not held up; the ring
// is read as a sample enters stage 1 and written back as it leaves, and
// consecutive samples hit distinct entries. A report goes through stage 1
// (products, ring read), stage 2 (sums), stage 3, output register (mean).
// Reset clears the valid bits of every ring entry, the sums and the timer
// at once; the interval register returns to 500 ms.
// A stalled receiver holds the report register; samples that cause no
// report keep flowing until two reports wait and a third reaches the sums.
// ----------------------------------------------------------------------------
module sensor_moving_average_reporter_unit #(
  parameter int unsigned AVG_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  smar_pkg::smar_in_t            sample,
  output logic                          report_valid,
  input  logic                          report_ready,
  output smar_pkg::smar_out_t           report,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [smar_pkg::ADDR_W-1:0]   paddr,
  input  logic [smar_pkg::DATA_W-1:0]   pwdata,
  output logic [smar_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned POS_W  = $clog2(AVG_DEPTH);
  localparam int unsigned TSUM_W = smar_pkg::TEMP_W + POS_W;
  localparam int unsigned BSUM_W = smar_pkg::BATT_W + POS_W;
  localparam logic [TSUM_W-1:0] AVG_BIAS = TSUM_W'(AVG_DEPTH - 1);

  logic [smar_pkg::INTERVAL_W-1:0] interval;

  logic [POS_W-1:0] ring_pos;

  logic                                 p1_valid;
  logic [POS_W-1:0]                     p1_pos;
  logic [smar_pkg::TEMP_PROD_W-1:0]     p1_temp_prod;
  logic [smar_pkg::BATT_PROD_W-1:0]     p1_batt_prod;
  logic [31:0]                          p1_now_ms;

  logic                   p2_valid;
  smar_pkg::smar_sample_t p2;

  logic                     p3_valid;
  logic signed [TSUM_W-1:0] p3_temp_sum;
  logic [BSUM_W-1:0]        p3_batt_sum;

  logic out_free;
  logic ready3;
  logic ready2;
  logic fire2;
  logic accept;
  logic move1;
  logic rep2;

  smar_pkg::smar_entry_t cur_entry;
  smar_pkg::smar_entry_t old_entry;

  logic signed [smar_pkg::TEMP_V_W-1:0] temp_v;
  logic signed [smar_pkg::TEMP_V_W-1:0] temp_adj;

  logic signed [TSUM_W-1:0] temp_sum_next;
  logic [BSUM_W-1:0]        battery_sum_next;
  logic [TSUM_W-1:0]        temp_avg_adj;

  assign out_free     = !report_valid || report_ready;
  assign ready3       = !p3_valid || out_free;
  assign ready2       = !p2_valid || !rep2 || ready3;
  assign fire2        = p2_valid && ready2;
  assign sample_ready = !p1_valid || ready2;
  assign accept       = sample_valid && sample_ready;
  assign move1        = p1_valid && ready2;

  smar_cfg_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .interval (interval)
  );

  // Stage 1: scale the samples and read the ring entry to be replaced.
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_pos <= '0;
      p1_valid <= 1'b0;
    end else begin
      if (accept) begin
        ring_pos <= ring_pos + POS_W'(1);
      end
      if (sample_ready) begin
        p1_valid <= sample_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_pos       <= ring_pos;
      p1_temp_prod <= smar_pkg::TEMP_PROD_W'(sample.temp_raw) * smar_pkg::TEMP_GAIN;
      p1_batt_prod <= smar_pkg::BATT_PROD_W'(sample.battery_raw) * smar_pkg::BATT_GAIN;
      p1_now_ms    <= sample.now_ms;
    end
  end

  smar_ring_mem #(
    .DEPTH (AVG_DEPTH),
    .POS_W (POS_W)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (ring_pos),
    .wr_en   (move1),
    .wr_addr (p1_pos),
    .wr_data (cur_entry),
    .rd_data (old_entry)
  );

  // Truncate toward zero on the temperature scale-down.
  always_comb begin
    temp_v   = $signed({1'b0, p1_temp_prod}) - $signed(smar_pkg::TEMP_OFFSET);
    temp_adj = temp_v + (temp_v[smar_pkg::TEMP_V_W-1] ? $signed(smar_pkg::TEMP_ROUND)
                                                      : $signed(smar_pkg::TEMP_V_W'(0)));
    cur_entry.temp    = $signed(temp_adj[smar_pkg::TEMP_V_W-1:smar_pkg::FRAC_W]);
    cur_entry.battery = p1_batt_prod[smar_pkg::BATT_PROD_W-1:smar_pkg::FRAC_W];
  end

  // Stage 2: write back the ring entry and update the sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (ready2) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2) begin
      p2.cur    <= cur_entry;
      p2.old    <= old_entry;
      p2.now_ms <= p1_now_ms;
    end
  end

  smar_accum #(
    .POS_W (POS_W)
  ) u_accum (
    .clk              (clk),
    .rst              (rst),
    .fire             (fire2),
    .sample           (p2),
    .interval         (interval),
    .report           (rep2),
    .temp_sum_next    (temp_sum_next),
    .battery_sum_next (battery_sum_next)
  );

  // Stage 3: hold the sums of a reporting sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else if (ready3) begin
      p3_valid <= fire2 && rep2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3) begin
      p3_temp_sum <= temp_sum_next;
      p3_batt_sum <= battery_sum_next;
    end
  end

  // Output register: means truncated toward zero.
  assign temp_avg_adj = p3_temp_sum + (p3_temp_sum[TSUM_W-1] ? AVG_BIAS : TSUM_W'(0));

  always_ff @(posedge clk) begin
    if (rst) begin
      report_valid <= 1'b0;
    end else if (out_free) begin
      report_valid <= p3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      report.avg_temp_tenths_c <= $signed(temp_avg_adj[TSUM_W-1:POS_W]);
      report.avg_battery_mv    <= p3_batt_sum[BSUM_W-1:POS_W];
    end
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sensor moving average reporter.
// Drives samples with random gaps while the report side stalls at random,
// predicts each report from its own copy of the rings, the running sums and
// the report timer, and compares every report field by field, in order.
// Reprograms the publish interval between phases while the unit is idle.
// ----------------------------------------------------------------------------
module testbench;
  import smar_pkg::*;

  localparam int AVG_DEPTH = 16;
  localparam int TEMP_SCALE = 3250;
  localparam int TEMP_ZERO = 555 * 1024;
  localparam int TEMP_DIV = 1024;
  localparam int unsigned BATT_SCALE = 82422;
  localparam int HOLD_CYCLES = 400;
  localparam logic [ADDR_W-1:0] INTERVAL_ADDR = ADDR_W'(4 * int'(REG_PUBLISH_INTERVAL));

  class avg_tracker;
    logic signed [TEMP_W-1:0] temp_hist [AVG_DEPTH];
    logic [BATT_W-1:0]        batt_hist [AVG_DEPTH];
    int                       slot;
    int                       temp_total;
    int unsigned              batt_total;
    logic [31:0]              last_ms;
    bit                       started;
    logic [INTERVAL_W-1:0]    interval;
    smar_out_t                pending_reports [$];
    int                       mismatches;

    function new();
      foreach (temp_hist[i]) begin
        temp_hist[i] = '0;
        batt_hist[i] = '0;
      end
      slot = 0;
      temp_total = 0;
      batt_total = 0;
      last_ms = '0;
      started = 1'b0;
      interval = INTERVAL_RESET;
      mismatches = 0;
    endfunction

    function void absorb_sample(smar_in_t s);
      int          temp_val;
      int unsigned batt_val;
      logic [31:0] gap;
      smar_out_t   due;
      temp_val = (int'(s.temp_raw) * TEMP_SCALE - TEMP_ZERO) / TEMP_DIV;
      batt_val = (32'(s.battery_raw) * BATT_SCALE) >> 10;
      if (!started) begin
        last_ms = s.now_ms;
        started = 1'b1;
      end
      temp_total = temp_total - temp_hist[slot] + temp_val;
      batt_total = batt_total - batt_hist[slot] + batt_val;
      temp_hist[slot] = TEMP_W'(temp_val);
      batt_hist[slot] = BATT_W'(batt_val);
      slot = (slot + 1) % AVG_DEPTH;
      gap = s.now_ms - last_ms;
      if (gap > 32'(interval)) begin
        due.avg_temp_tenths_c = TEMP_W'(temp_total / AVG_DEPTH);
        due.avg_battery_mv = BATT_W'(batt_total / AVG_DEPTH);
        pending_reports.push_back(due);
        last_ms = s.now_ms;
      end
    endfunction

    function void compare_report(smar_out_t got);
      smar_out_t want;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected report: temp %0d, battery %0d mV",
                   got.avg_temp_tenths_c, got.avg_battery_mv);
        end
      end else begin
        want = pending_reports.pop_front();
        if (got.avg_temp_tenths_c !== want.avg_temp_tenths_c ||
            got.avg_battery_mv !== want.avg_battery_mv) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("report mismatch: temp expected %0d got %0d, battery expected %0d got %0d",
                     want.avg_temp_tenths_c, got.avg_temp_tenths_c,
                     want.avg_battery_mv, got.avg_battery_mv);
          end
        end
      end
    endfunction

    function void check_interval(logic [INTERVAL_W-1:0] got);
      if (got !== interval) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("interval readback: expected %0d got %0d", interval, got);
        end
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              sample_valid = 1'b0;
  logic              sample_ready;
  smar_in_t          sample = '0;
  logic              report_valid;
  logic              report_ready = 1'b0;
  smar_out_t         report;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  avg_tracker        tracker;
  int                snd_idle_pct = 0;
  int                rcv_idle_pct = 0;
  int                hold_reqs = 0;
  int                holds_taken = 0;
  int                hold_left = 0;
  logic [31:0]       clock_ms = '0;
  logic [RAW_W-1:0]  edge_raws [10] = '{0, 1, 173, 174, 175, 176, 511, 512, 1022, 1023};

  sensor_moving_average_reporter_unit #(
    .AVG_DEPTH(AVG_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample(sample),
    .report_valid(report_valid),
    .report_ready(report_ready),
    .report(report),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      report_ready <= 1'b0;
    end else begin
      if (report_valid && report_ready) begin
        tracker.compare_report(report);
      end
      if (holds_taken != hold_reqs) begin
        holds_taken = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        report_ready <= 1'b0;
      end else begin
        report_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  task automatic send_sample(input logic [RAW_W-1:0] t_raw, input logic [RAW_W-1:0] b_raw,
                             input logic [31:0] ms);
    smar_in_t s;
    s.temp_raw = t_raw;
    s.battery_raw = b_raw;
    s.now_ms = ms;
    sample_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (!sample_ready);
    tracker.absorb_sample(s);
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      sample_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < snd_idle_pct);
    end
  endtask

  task automatic apb_xfer(input bit wr, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= INTERVAL_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (wr) begin
      tracker.interval = value[INTERVAL_W-1:0];
    end else begin
      tracker.check_interval(prdata[INTERVAL_W-1:0]);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_interval(input logic [DATA_W-1:0] value);
    apb_xfer(1'b0, '0);
    apb_xfer(1'b1, value);
    apb_xfer(1'b0, '0);
  endtask

  // hold input until every report is back, then let the pipeline empty
  task automatic drain();
    sample_valid <= 1'b0;
    while (tracker.pending_reports.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic run_random(input int count, input int hold_at);
    int unsigned pick;
    int unsigned span;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      span = 32'(tracker.interval);
      if (pick < 3) begin
        clock_ms = $urandom();
      end else if (pick < 8) begin
        clock_ms += span + $urandom_range(0, 3);
      end else begin
        clock_ms += $urandom_range(0, span / 8 + 2);
      end
      if (i == hold_at) begin
        hold_reqs++;
      end
      send_sample(RAW_W'($urandom_range(0, 1023)), RAW_W'($urandom_range(0, 1023)), clock_ms);
    end
  endtask

  initial begin
    #4_000_000;
    $display("** sensor_moving_average_reporter_unit: FAILED **");
    $finish;
  end

  initial begin
    tracker = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    snd_idle_pct = 33;
    rcv_idle_pct = 68;

    clock_ms = 32'hFFFF_FF00;
    send_sample(10'd0, 10'd0, clock_ms);
    send_sample(10'd1023, 10'd1023, clock_ms + 32'd500);
    send_sample(10'd174, 10'h155, clock_ms + 32'd501);
    send_sample(10'd175, 10'h2AA, clock_ms + 32'd501);
    clock_ms += 32'd501;
    foreach (edge_raws[k]) begin
      clock_ms += 32'd120;
      send_sample(edge_raws[k], edge_raws[9 - k], clock_ms);
    end

    drain();
    program_interval(32'd0);
    send_sample(10'd512, 10'd0, clock_ms);
    send_sample(10'd1, 10'd1, clock_ms);
    clock_ms += 32'd1;
    send_sample(10'd0, 10'd1023, clock_ms);

    drain();
    program_interval({16'hA5C3, 16'hFFFF});
    send_sample(10'd1023, 10'd0, clock_ms + 32'd65535);
    send_sample(10'd0, 10'd1023, clock_ms + 32'd65536);
    send_sample(10'h2AA, 10'h155, clock_ms);

    drain();
    program_interval(32'($urandom_range(0, 65535)));
    run_random(480, 100);

    drain();
    snd_idle_pct = 68;
    rcv_idle_pct = 33;
    program_interval(32'($urandom_range(1, 200)));
    clock_ms = 32'hFFFF_F000;
    run_random(480, -1);

    drain();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    program_interval({16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))});
    run_random(490, 150);

    drain();
    if (tracker.mismatches == 0) begin
      $display("** sensor_moving_average_reporter_unit: PASSED **");
    end else begin
      $display("** sensor_moving_average_reporter_unit: FAILED **");
    end
    $finish;
  end

endmodule

/* sensor_moving_average_reporter_unit.f */
rtl/core/smar_pkg.sv
rtl/core/smar_cfg_regs.sv
rtl/core/smar_ring_mem.sv
rtl/core/smar_accum.sv
rtl/core/sensor_moving_average_reporter_unit.sv
tb/testbench.sv
